// ----- hw/rtl/ral_pkg.sv -----
// shared types, sizes and codes for the request admission limiter
`timescale 1ns / 1ps
package ral_pkg;

   // store sizes
   localparam int USER_COUNT = 256;
   localparam int IMM_DEPTH = 4;
   localparam int WL_DEPTH = 1024;

   // field and register widths
   localparam int UID_W = 8;
   localparam int VAL_W = 32;
   localparam int CNT_W = 8;
   localparam int ULIM_W = 8;
   localparam int ILIM_W = 3;
   localparam int WLIM_W = 11;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 11;

   // derived widths
   localparam int CNT_AW = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
   localparam int IMM_AW = (IMM_DEPTH > 1) ? $clog2(IMM_DEPTH) : 1;
   localparam int IMM_CW = $clog2(IMM_DEPTH + 1);
   localparam int WL_AW = (WL_DEPTH > 1) ? $clog2(WL_DEPTH) : 1;
   localparam int WL_CW = $clog2(WL_DEPTH + 1);
   localparam int ICAP_W = (ILIM_W > IMM_CW) ? ILIM_W : IMM_CW;
   localparam int WCAP_W = (WLIM_W > WL_CW) ? WLIM_W : WL_CW;
   localparam int MV_W = (IMM_CW > WL_CW) ? IMM_CW : WL_CW;

   // register reset values
   localparam logic [ULIM_W-1:0] USER_LIMIT_RST = ULIM_W'(100);
   localparam logic [ILIM_W-1:0] IMM_LIMIT_RST = ILIM_W'(3);
   localparam logic [WLIM_W-1:0] WL_LIMIT_RST = WLIM_W'(1000);

   typedef enum logic [0:0] {
      CMD_ARRIVAL = 1'b0,
      CMD_TICK    = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STS_IMMEDIATE = 3'd0,
      STS_WAITLIST  = 3'd1,
      STS_OVERQUOTA = 3'd2,
      STS_OVERLOAD  = 3'd3,
      STS_RELEASED  = 3'd4
   } status_type;

   typedef enum logic [CSR_IW-1:0] {
      REG_USER_LIMIT = 2'd0,
      REG_IMM_LIMIT  = 2'd1,
      REG_WL_LIMIT   = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_index_type;

endpackage

// ----- hw/rtl/ral_req_if.sv -----
// request channel: arrivals and release ticks
`timescale 1ns / 1ps
interface ral_req_if;
   import ral_pkg::*;

   logic valid;
   logic ready;
   logic cmd;
   logic [UID_W-1:0] user_id;
   logic signed [VAL_W-1:0] request_value;

   modport source (output valid, output cmd, output user_id, output request_value,
                   input ready);
   modport sink (input valid, input cmd, input user_id, input request_value,
                 output ready);
endinterface

// ----- hw/rtl/ral_rsp_if.sv -----
// response channel: admission status and released items
`timescale 1ns / 1ps
interface ral_rsp_if;
   import ral_pkg::*;

   logic valid;
   logic ready;
   logic [2:0] status;
   logic signed [VAL_W-1:0] released_value;
   logic last;

   modport source (output valid, output status, output released_value, output last,
                   input ready);
   modport sink (input valid, input status, input released_value, input last,
                 output ready);
endinterface

// ----- hw/rtl/ral_csr_if.sv -----
// configuration write channel
`timescale 1ns / 1ps
interface ral_csr_if;
   import ral_pkg::*;

   logic valid;
   logic ready;
   logic [CSR_IW-1:0] reg_index;
   logic [CSR_DW-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ----- hw/rtl/ral_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module ral_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/request_admission_limiter_unit.sv -----
// top level: per-user quota check, immediate queue and waitlist with tick release
// Usage
//   req_chan carries one item per handshake: cmd arrival (user_id, request_value)
//   or cmd tick. rsp_chan returns results; csr_chan writes user_limit (index 0),
//   immediate_limit (index 1) and waitlist_limit (index 2), always ready.
//   An arrival gives one result (status, released_value zero, last set). Its
//   result is registered in S_ARRIVE once the result register is free, and the
//   next item is accepted only back in S_IDLE. The per-user count lives in a
//   ram: read on acceptance, checked and written back in S_ARRIVE once the
//   result register is free.
//   A tick gives one released result per cycle while the result register is
//   free, for every entry of the immediate queue, last on the final one, then
//   refills it from the waitlist ram at one entry per cycle, up to the immediate
//   capacity (at most 4); each read lands in the queue from the registered ram
//   output, and the next item is accepted once the last read has landed.
//   Reset sets the registers to 100, 3, 1000 and then sweeps all USER_COUNT
//   (256) entries of the count ram, one entry per cycle, with req_chan not ready.
//   A stalled receiver holds the result register; an item can still be
//   accepted, and its processing waits for the result register to free up.
`timescale 1ns / 1ps
module request_admission_limiter_unit (
   input  logic      clock,
   input  logic      reset,
   ral_req_if.sink   req_chan,
   ral_rsp_if.source rsp_chan,
   ral_csr_if.sink   csr_chan
);
   import ral_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ARRIVE,
      S_RELEASE,
      S_REFILL
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [CNT_AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [ULIM_W-1:0]   user_limit_ff, user_limit_in;
   logic [ILIM_W-1:0]   imm_limit_ff, imm_limit_in;
   logic [WLIM_W-1:0]   wl_limit_ff, wl_limit_in;
   logic [IMM_CW-1:0]   imm_fill_ff, imm_fill_in;
   logic [WL_AW-1:0]    wl_head_ff, wl_head_in;
   logic [WL_CW-1:0]    wl_fill_ff, wl_fill_in;
   logic [IMM_CW-1:0]   rel_ff, rel_in;
   logic [IMM_CW-1:0]   mv_cnt_ff, mv_cnt_in;
   logic [IMM_CW-1:0]   move_ff, move_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   // payload registers
   logic [VAL_W-1:0]    imm_q_ff [IMM_DEPTH];
   logic [VAL_W-1:0]    imm_q_in [IMM_DEPTH];
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [CNT_AW-1:0]   uid_ff, uid_in;
   logic [IMM_AW-1:0]   pidx_ff, pidx_in;

   // memory ports
   logic                cnt_we, cnt_re;
   logic [CNT_AW-1:0]   cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
   logic                wl_we, wl_re;
   logic [WL_AW-1:0]    wl_waddr;
   logic [VAL_W-1:0]    wl_rdata;

   // derived values
   logic                req_accept;
   logic                slot_free;
   logic [IMM_CW-1:0]   imm_cap;
   logic [WL_CW-1:0]    wl_cap;
   logic [IMM_CW-1:0]   refill_amt;
   logic [WL_CW:0]      tail_sum;
   logic [CNT_AW-1:0]   req_uid;
   logic                refill_issue;

   ral_ram #(.WIDTH(CNT_W), .DEPTH(USER_COUNT)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cnt_re),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   ral_ram #(.WIDTH(VAL_W), .DEPTH(WL_DEPTH)) u_waitlist_ram (
      .clock (clock),
      .we    (wl_we),
      .waddr (wl_waddr),
      .wdata (val_ff),
      .re    (wl_re),
      .raddr (wl_head_ff),
      .rdata (wl_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_uid = CNT_AW'(req_chan.user_id % USER_COUNT);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.released_value = rsp_value_ff;
   assign rsp_chan.last = rsp_last_ff;

   // capacities saturate at the store depth
   assign imm_cap = (ICAP_W'(imm_limit_ff) > ICAP_W'(IMM_DEPTH)) ? IMM_CW'(IMM_DEPTH)
                                                                  : IMM_CW'(imm_limit_ff);
   assign wl_cap = (WCAP_W'(wl_limit_ff) > WCAP_W'(WL_DEPTH)) ? WL_CW'(WL_DEPTH)
                                                              : WL_CW'(wl_limit_ff);
   assign refill_amt = (MV_W'(imm_cap) > MV_W'(wl_fill_ff)) ? IMM_CW'(wl_fill_ff) : imm_cap;

   // tail of the circular waitlist
   assign tail_sum = (WL_CW + 1)'(wl_head_ff) + (WL_CW + 1)'(wl_fill_ff);
   assign wl_waddr = (tail_sum >= (WL_CW + 1)'(WL_DEPTH))
                   ? WL_AW'(tail_sum - (WL_CW + 1)'(WL_DEPTH)) : WL_AW'(tail_sum);

   assign refill_issue = (state_ff == S_REFILL) && (mv_cnt_ff < move_ff);

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      user_limit_in = user_limit_ff;
      imm_limit_in = imm_limit_ff;
      wl_limit_in = wl_limit_ff;
      imm_fill_in = imm_fill_ff;
      wl_head_in = wl_head_ff;
      wl_fill_in = wl_fill_ff;
      rel_in = rel_ff;
      mv_cnt_in = mv_cnt_ff;
      move_in = move_ff;
      pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;
      imm_q_in = imm_q_ff;
      val_in = val_ff;
      uid_in = uid_ff;
      pidx_in = pidx_ff;
      cnt_we = 1'b0;
      cnt_waddr = uid_ff;
      cnt_wdata = '0;
      cnt_re = 1'b0;
      cnt_raddr = req_uid;
      wl_we = 1'b0;
      wl_re = 1'b0;

      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            REG_USER_LIMIT: user_limit_in = ULIM_W'(csr_chan.write_data);
            REG_IMM_LIMIT:  imm_limit_in = ILIM_W'(csr_chan.write_data);
            REG_WL_LIMIT:   wl_limit_in = WLIM_W'(csr_chan.write_data);
            default:        ;
         endcase
      end

      // a refill read lands in the cycle after it was issued
      if (pend_ff) begin
         imm_q_in[pidx_ff] = wl_rdata;
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_we = 1'b1;
            cnt_waddr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CNT_AW'(USER_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               val_in = req_chan.request_value;
               uid_in = req_uid;
               rel_in = '0;
               if (req_chan.cmd == CMD_TICK) begin
                  state_in = S_RELEASE;
               end else begin
                  cnt_re = 1'b1;
                  state_in = S_ARRIVE;
               end
            end
         end
         S_ARRIVE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
               if (cnt_rdata > user_limit_ff) begin
                  rsp_status_in = STS_OVERQUOTA;
               end else begin
                  // count never passes limit+1, held at all ones
                  cnt_we = 1'b1;
                  cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
                  if (imm_fill_ff < imm_cap) begin
                     imm_q_in[IMM_AW'(imm_fill_ff)] = val_ff;
                     imm_fill_in = imm_fill_ff + 1'b1;
                     rsp_status_in = STS_IMMEDIATE;
                  end else if (wl_fill_ff < wl_cap) begin
                     wl_we = 1'b1;
                     wl_fill_in = wl_fill_ff + 1'b1;
                     rsp_status_in = STS_WAITLIST;
                  end else begin
                     rsp_status_in = STS_OVERLOAD;
                  end
               end
            end
         end
         S_RELEASE: begin
            if (rel_ff == imm_fill_ff) begin
               imm_fill_in = '0;
               move_in = refill_amt;
               mv_cnt_in = '0;
               state_in = S_REFILL;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_RELEASED;
               rsp_value_in = imm_q_ff[IMM_AW'(rel_ff)];
               rsp_last_in = ((rel_ff + 1'b1) == imm_fill_ff);
               rel_in = rel_ff + 1'b1;
            end
         end
         S_REFILL: begin
            if (refill_issue) begin
               wl_re = 1'b1;
               wl_head_in = (wl_head_ff == WL_AW'(WL_DEPTH - 1)) ? '0 : wl_head_ff + 1'b1;
               wl_fill_in = wl_fill_ff - 1'b1;
               mv_cnt_in = mv_cnt_ff + 1'b1;
               pend_in = 1'b1;
               pidx_in = IMM_AW'(mv_cnt_ff);
            end else if (!pend_ff) begin
               imm_fill_in = move_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_addr_ff <= '0;
         user_limit_ff <= USER_LIMIT_RST;
         imm_limit_ff <= IMM_LIMIT_RST;
         wl_limit_ff <= WL_LIMIT_RST;
         imm_fill_ff <= '0;
         wl_head_ff <= '0;
         wl_fill_ff <= '0;
         rel_ff <= '0;
         mv_cnt_ff <= '0;
         move_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_status_ff <= STS_IMMEDIATE;
         rsp_value_ff <= '0;
         rsp_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         user_limit_ff <= user_limit_in;
         imm_limit_ff <= imm_limit_in;
         wl_limit_ff <= wl_limit_in;
         imm_fill_ff <= imm_fill_in;
         wl_head_ff <= wl_head_in;
         wl_fill_ff <= wl_fill_in;
         rel_ff <= rel_in;
         mv_cnt_ff <= mv_cnt_in;
         move_ff <= move_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      imm_q_ff <= imm_q_in;
      val_ff <= val_in;
      uid_ff <= uid_in;
      pidx_ff <= pidx_in;
   end

   // checks
   a_wl_fill_bound: assert property (@(posedge clock) disable iff (reset)
      wl_fill_ff <= WL_CW'(WL_DEPTH))
      else $error("waitlist fill beyond depth");

   a_imm_fill_bound: assert property (@(posedge clock) disable iff (reset)
      imm_fill_ff <= IMM_CW'(IMM_DEPTH))
      else $error("immediate fill beyond depth");

   a_pend_in_refill: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == S_REFILL)
      else $error("refill read landed outside refill");

   a_nonlast_only_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_last_in && !(rsp_valid_ff && !rsp_chan.ready))
         |-> state_ff == S_RELEASE)
      else $error("non-final result outside release");

   a_arrive_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ARRIVE && slot_free) |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("arrival did not complete");

endmodule

// ----- sim/request_admission_limiter_unit_tb.sv -----
// self-checking testbench for request_admission_limiter_unit with a built-in admission predictor
`timescale 1ns / 1ps
module request_admission_limiter_unit_tb;
   import ral_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      cmd_type cmd;
      logic [UID_W-1:0] uid;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct {
      status_type status;
      logic signed [VAL_W-1:0] value;
      logic last;
   } rsp_item_type;

   typedef struct {
      reg_index_type idx;
      logic [CSR_DW-1:0] data;
   } reg_write_type;

   logic clock;
   logic reset;

   ral_req_if req_chan();
   ral_rsp_if rsp_chan();
   ral_csr_if csr_chan();

   request_admission_limiter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // stimulus and expected results
   req_item_type request_backlog[$];
   reg_write_type reg_writes[$];
   rsp_item_type owed_results[$];

   // predictor state
   int quota_lim;
   int fast_lim;
   int wait_lim;
   logic [CNT_W-1:0] user_tally[USER_COUNT];
   logic signed [VAL_W-1:0] fast_q[IMM_DEPTH];
   int fast_fill;
   logic signed [VAL_W-1:0] wait_q[WL_DEPTH];
   logic [WL_AW-1:0] wait_head;
   int wait_fill;

   // handshake bookkeeping
   bit req_busy;
   bit req_taken;
   bit csr_busy;
   bit csr_taken;
   bit pace_on;
   int gap_left;
   int stall_left;
   int mismatch_count;
   int cycle_count;

   always #4 clock = ~clock;

   function automatic int fast_cap();
      return (fast_lim > IMM_DEPTH) ? IMM_DEPTH : fast_lim;
   endfunction

   function automatic int wait_cap();
      return (wait_lim > WL_DEPTH) ? WL_DEPTH : wait_lim;
   endfunction

   function automatic int pace_draw();
      return pace_on ? $urandom_range(9, 0) : 0;
   endfunction

   task automatic owe(status_type status, logic signed [VAL_W-1:0] value, logic last);
      rsp_item_type r;
      r.status = status;
      r.value = value;
      r.last = last;
      owed_results.push_back(r);
   endtask

   task automatic admit_or_release(req_item_type item);
      int cnt;
      int sat;
      int n;
      int move;
      if (item.cmd == CMD_ARRIVAL) begin
         cnt = user_tally[item.uid];
         if (cnt > quota_lim) begin
            owe(STS_OVERQUOTA, '0, 1'b1);
         end else begin
            sat = (quota_lim + 1 > 255) ? 255 : quota_lim + 1;
            if (cnt < sat) cnt++;
            user_tally[item.uid] = CNT_W'(cnt);
            if (fast_fill < fast_cap()) begin
               fast_q[fast_fill] = item.value;
               fast_fill++;
               owe(STS_IMMEDIATE, '0, 1'b1);
            end else if (wait_fill < wait_cap()) begin
               wait_q[WL_AW'(wait_head + wait_fill)] = item.value;
               wait_fill++;
               owe(STS_WAITLIST, '0, 1'b1);
            end else begin
               owe(STS_OVERLOAD, '0, 1'b1);
            end
         end
      end else begin
         n = fast_fill;
         for (int k = 0; k < n; k++) owe(STS_RELEASED, fast_q[k], k == n - 1);
         // refill from the waitlist head into the emptied immediate queue
         move = (fast_cap() < wait_fill) ? fast_cap() : wait_fill;
         for (int i = 0; i < move; i++) begin
            fast_q[i] = wait_q[wait_head];
            wait_head = wait_head + 1'b1;
         end
         wait_fill -= move;
         fast_fill = move;
      end
   endtask

   task automatic apply_reg(reg_index_type idx, logic [CSR_DW-1:0] data);
      case (idx)
         REG_USER_LIMIT: quota_lim = data[ULIM_W-1:0];
         REG_IMM_LIMIT: fast_lim = data[ILIM_W-1:0];
         REG_WL_LIMIT: wait_lim = data[WLIM_W-1:0];
         default: ;
      endcase
   endtask

   // driver: all inputs change on the falling edge
   always @(negedge clock) begin
      req_item_type item;
      reg_write_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
         csr_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b1;
      end else begin
         if (req_busy && req_taken) begin
            req_busy = 0;
            req_taken = 0;
            gap_left = pace_draw();
         end
         if (!req_busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_backlog.size() > 0) begin
               item = request_backlog.pop_front();
               req_chan.cmd <= item.cmd;
               req_chan.user_id <= item.uid;
               req_chan.request_value <= item.value;
               req_busy = 1;
            end
         end
         req_chan.valid <= req_busy;

         if (csr_busy && csr_taken) begin
            csr_busy = 0;
            csr_taken = 0;
         end
         if (!csr_busy && reg_writes.size() > 0) begin
            w = reg_writes.pop_front();
            csr_chan.reg_index <= w.idx;
            csr_chan.write_data <= w.data;
            csr_busy = 1;
         end
         csr_chan.valid <= csr_busy;

         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // monitor: handshakes sampled on the rising edge
   always @(posedge clock) begin
      req_item_type item;
      rsp_item_type want;
      cycle_count++;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            item.cmd = cmd_type'(req_chan.cmd);
            item.uid = req_chan.user_id;
            item.value = req_chan.request_value;
            admit_or_release(item);
            req_taken = 1;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            apply_reg(reg_index_type'(csr_chan.reg_index), csr_chan.write_data);
            csr_taken = 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_results.size() == 0) begin
               $error("unexpected item: status %0d value %0d last %0b",
                      rsp_chan.status, rsp_chan.released_value, rsp_chan.last);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_chan.status);
                  mismatch_count++;
               end
               if (rsp_chan.released_value !== want.value) begin
                  $error("released_value expected %0d actual %0d",
                         want.value, rsp_chan.released_value);
                  mismatch_count++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last expected %0b actual %0b", want.last, rsp_chan.last);
                  mismatch_count++;
               end
            end
            stall_left = pace_draw();
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_item(cmd_type cmd, logic [UID_W-1:0] uid, logic signed [VAL_W-1:0] value);
      req_item_type item;
      item.cmd = cmd;
      item.uid = uid;
      item.value = value;
      request_backlog.push_back(item);
   endtask

   task automatic add_tick();
      add_item(CMD_TICK, UID_W'($urandom), $urandom);
   endtask

   // hold the sender until every item is in and every result is back
   task automatic drain();
      while (request_backlog.size() > 0 || req_busy || owed_results.size() > 0)
         @(posedge clock);
   endtask

   // a tick with an empty immediate queue may still be refilling
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(int ulim, int ilim, int wlim);
      reg_write_type w;
      w.idx = REG_USER_LIMIT;
      w.data = CSR_DW'(ulim);
      reg_writes.push_back(w);
      w.idx = REG_IMM_LIMIT;
      w.data = CSR_DW'(ilim);
      reg_writes.push_back(w);
      w.idx = REG_WL_LIMIT;
      w.data = CSR_DW'(wlim);
      reg_writes.push_back(w);
      while (reg_writes.size() > 0 || csr_busy) @(posedge clock);
   endtask

   task automatic fill_random(int count, int user_span, int tick_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99, 0) < tick_pct)
            add_tick();
         else
            add_item(CMD_ARRIVAL, UID_W'($urandom_range(user_span - 1, 0)), $urandom);
      end
   endtask

   task automatic random_phase(int ulim, int ilim, int wlim, int user_span, int tick_pct,
                               bit paced);
      settle();
      write_regs(ulim, ilim, wlim);
      pace_on = paced;
      fill_random(40, user_span, tick_pct);
   endtask

   initial begin
      reg_write_type junk;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = 1'b0;
      req_chan.user_id = '0;
      req_chan.request_value = '0;
      rsp_chan.ready = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.reg_index = '0;
      csr_chan.write_data = '0;
      quota_lim = USER_LIMIT_RST;
      fast_lim = IMM_LIMIT_RST;
      wait_lim = WL_LIMIT_RST;
      foreach (user_tally[i]) user_tally[i] = '0;
      fast_fill = 0;
      wait_head = '0;
      wait_fill = 0;
      pace_on = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: fill the immediate queue, spill two into the waitlist
      add_item(CMD_ARRIVAL, 8'd0, 32'sh7FFFFFFF);
      add_item(CMD_ARRIVAL, 8'd255, 32'sh80000000);
      add_item(CMD_ARRIVAL, 8'd1, 32'sh00000000);
      add_item(CMD_ARRIVAL, 8'd128, 32'shFFFFFFFF);
      add_item(CMD_ARRIVAL, 8'd127, 32'sh55555555);
      add_tick();
      add_tick();
      add_tick();   // empty immediate queue, nothing released
      settle();

      // zero capacity everywhere and a zero quota
      write_regs(0, 0, 0);
      junk.idx = REG_UNUSED;
      junk.data = '1;
      reg_writes.push_back(junk);
      while (reg_writes.size() > 0 || csr_busy) @(posedge clock);
      add_item(CMD_ARRIVAL, 8'd5, 32'sh12345678);
      add_item(CMD_ARRIVAL, 8'd5, 32'sh12345678);
      add_tick();
      settle();

      // one slot in each tier
      write_regs(0, 1, 1);
      add_item(CMD_ARRIVAL, 8'd6, 32'shAAAAAAAA);
      add_item(CMD_ARRIVAL, 8'd7, 32'sh0F0F0F0F);
      add_item(CMD_ARRIVAL, 8'd8, 32'sh00000001);
      add_item(CMD_ARRIVAL, 8'd5, 32'sh00000002);
      add_tick();
      add_tick();
      settle();

      // count saturation at limit plus one
      write_regs(1, 4, 1024);
      add_item(CMD_ARRIVAL, 8'd9, 32'sh00000003);
      add_item(CMD_ARRIVAL, 8'd9, 32'sh00000004);
      add_item(CMD_ARRIVAL, 8'd9, 32'sh00000005);
      add_tick();

      random_phase(3, 3, 6, 4, 20, 1);
      random_phase(254, 4, 1024, 256, 25, 0);
      random_phase(0, 1, 2, 8, 30, 1);
      // upper data bits are dropped, capacities above the store saturate
      random_phase(11'h7FF, 7, 2047, 2, 20, 1);
      random_phase(12, 2, 10, 16, 35, 1);
      random_phase(100, 3, 1000, 64, 30, 0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_results.size() > 0) begin
         $error("%0d expected items never arrived", owed_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
